FILE: design/clqt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package clqt_pkg;

    // request codes
    localparam logic [1:0] REQ_VOTE    = 2'd0;
    localparam logic [1:0] REQ_CHOSEN  = 2'd1;
    localparam logic [1:0] REQ_DELIVER = 2'd2;
    localparam logic [1:0] REQ_HOLES   = 2'd3;

    // result status codes
    localparam logic [3:0] ST_OUTDATED   = 4'd0;
    localparam logic [3:0] ST_ALREADY    = 4'd1;
    localparam logic [3:0] ST_OLD_BALLOT = 4'd2;
    localparam logic [3:0] ST_DUPLICATE  = 4'd3;
    localparam logic [3:0] ST_COUNTED    = 4'd4;
    localparam logic [3:0] ST_CHOSEN     = 4'd5;
    localparam logic [3:0] ST_DELIVERED  = 4'd6;
    localparam logic [3:0] ST_NONE       = 4'd7;
    localparam logic [3:0] ST_OVERFLOW   = 4'd8;
    localparam logic [3:0] ST_HOLES      = 4'd9;

    // configuration register indexes
    localparam logic [1:0] CFG_QUORUM    = 2'd0;
    localparam logic [1:0] CFG_ACCEPTORS = 2'd1;
    localparam logic [1:0] CFG_CATCH_UP  = 2'd2;
    localparam logic [1:0] CFG_START     = 2'd3;

    localparam int MAX_ACCEPTORS = 16;
    localparam int VOTE_W        = 16;

    // one request as it travels from front to back
    typedef struct packed {
        logic        sync;
        logic [1:0]  req;
        logic [31:0] inst;
        logic [31:0] bnum;
        logic [7:0]  bprop;
        logic [3:0]  aid;
        logic [31:0] val;
    } item_t;

    // one instance table entry
    typedef struct packed {
        logic [31:0]       inst;
        logic [31:0]       bnum;
        logic [7:0]        bprop;
        logic [VOTE_W-1:0] votes;
        logic [31:0]       val;
        logic              chosen;
    } entry_t;

    // one result transaction
    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] inst;
        logic [31:0] bnum;
        logic [7:0]  bprop;
        logic [31:0] val;
        logic        has_holes;
        logic [31:0] hole_from;
        logic [31:0] hole_to;
    } result_t;

endpackage
`default_nettype wire

FILE: design/clqt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module clqt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

FILE: design/clqt_front.sv
`timescale 1ns / 1ps
`default_nettype none
module clqt_front #(
    parameter int WINDOW = 64
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire clqt_pkg::item_t           s_item,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [31:0]               cfg_wdata,
    output logic                           push,
    output clqt_pkg::item_t                push_item,
    output logic [$clog2(WINDOW)-1:0]      push_slot,
    input  wire logic                      q_full
);
    import clqt_pkg::*;

    localparam int IDXW = $clog2(WINDOW);
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / WINDOW);

    logic            v1_reg, v2_reg, v3_reg;
    item_t           it1_reg, it2_reg, it3_reg;
    logic [31:0]     q1_reg;
    logic [IDXW:0]   r2_reg;
    logic [IDXW-1:0] slot3_reg;
    logic            advance, inject, take;
    item_t           it_in;
    logic [63:0]     prod;
    logic [31:0]     qw, rem;

    assign advance = !(v3_reg && q_full);
    assign inject  = cfg_we && (cfg_index == CFG_START);
    assign s_ready = advance && !cfg_we && aresetn;
    assign take    = s_valid && s_ready;
    assign push      = v3_reg && !q_full;
    assign push_item = it3_reg;
    assign push_slot = slot3_reg;

    // start_instance write sends a sync marker carrying the new next instance
    always_comb begin
        it_in = s_item;
        it_in.sync = 1'b0;
        if (inject) begin
            it_in = '0;
            it_in.sync = 1'b1;
            it_in.inst = cfg_wdata + 32'd1;
        end
    end

    // quotient estimate by reciprocal, then remainder and one correction
    assign prod = 64'(it_in.inst) * 64'(RECIP);
    assign qw   = q1_reg * 32'(WINDOW);
    assign rem  = it1_reg.inst - qw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= take || inject;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            it1_reg <= it_in;
            q1_reg  <= prod[63:32];
            it2_reg <= it1_reg;
            r2_reg  <= rem[IDXW:0];
            it3_reg <= it2_reg;
            if (r2_reg >= (IDXW+1)'(WINDOW)) begin
                slot3_reg <= IDXW'(r2_reg - (IDXW+1)'(WINDOW));
            end else begin
                slot3_reg <= r2_reg[IDXW-1:0];
            end
        end
    end
endmodule
`default_nettype wire

FILE: design/clqt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module clqt_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] head,
    output logic                  not_empty,
    output logic                  full
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign head      = mem_reg[rp_reg];
    assign not_empty = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);

    // two-entry circular buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

FILE: design/clqt_back.sv
`timescale 1ns / 1ps
`default_nettype none
module clqt_back #(
    parameter int WINDOW = 64
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      q_valid,
    input  wire clqt_pkg::item_t           q_item,
    input  wire logic [$clog2(WINDOW)-1:0] q_slot,
    output logic                           q_pop,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [31:0]               cfg_wdata,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output clqt_pkg::result_t              m_result
);
    import clqt_pkg::*;

    localparam int IDXW = $clog2(WINDOW);

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t          state_reg;
    item_t           item_reg;
    logic [IDXW-1:0] slot_reg, nte_slot_reg, rd_addr;
    logic [31:0]     nte_reg, hc_reg;
    logic            await_reg;
    logic [4:0]      quorum_reg, acc_reg;
    logic [WINDOW-1:0] valid_reg;
    logic            m_valid_reg;
    result_t         res_reg, res;

    entry_t          cur, base, wr_entry;
    logic            commit, ram_we, vbit, stale, choose, dlv_hit;
    logic [31:0]     eff_nte, inst_gap;
    logic [6:0]      limit;
    logic [VOTE_W-1:0] bit_mask, votes2;
    logic [4:0]      cnt;
    logic            newer, older;

    assign m_valid  = m_valid_reg;
    assign m_result = res_reg;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign commit   = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);
    assign rd_addr  = (state_reg == S_EXEC) ? slot_reg :
                      (q_item.req == REQ_DELIVER) ? nte_slot_reg : q_slot;

    clqt_ram #(.WIDTH($bits(entry_t)), .DEPTH(WINDOW)) u_table (
        .aclk    (aclk),
        .wr_en   (commit && ram_we),
        .wr_addr (slot_reg),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (cur)
    );

    // request processing on the slot read back from the table
    always_comb begin
        vbit     = valid_reg[slot_reg];
        eff_nte  = await_reg ? item_reg.inst : nte_reg;
        inst_gap = item_reg.inst - eff_nte;
        stale    = !vbit || (cur.inst != item_reg.inst);
        base     = cur;
        if (stale) begin
            base = '0;
            base.inst = item_reg.inst;
        end
        limit    = (acc_reg < 5'(MAX_ACCEPTORS)) ? 7'(acc_reg) : 7'(MAX_ACCEPTORS);
        newer    = (item_reg.bnum > base.bnum) ||
                   ((item_reg.bnum == base.bnum) && (item_reg.bprop > base.bprop));
        older    = (item_reg.bnum < base.bnum) ||
                   ((item_reg.bnum == base.bnum) && (item_reg.bprop < base.bprop));
        bit_mask = VOTE_W'(1) << item_reg.aid;
        dlv_hit  = vbit && (cur.inst == nte_reg) && cur.chosen;
        wr_entry = base;
        ram_we   = 1'b0;
        choose   = 1'b0;
        votes2   = '0;
        cnt      = '0;
        res      = '0;
        unique case (item_reg.req)
            REQ_DELIVER: begin
                if (dlv_hit) begin
                    res.status = ST_DELIVERED;
                    res.inst   = nte_reg;
                    res.bnum   = cur.bnum;
                    res.bprop  = cur.bprop;
                    res.val    = cur.val;
                end else begin
                    res.status = ST_NONE;
                end
            end
            REQ_HOLES: begin
                if (hc_reg > nte_reg) begin
                    res.status    = ST_HOLES;
                    res.has_holes = 1'b1;
                    res.hole_from = nte_reg;
                    res.hole_to   = hc_reg;
                end else begin
                    res.status = ST_NONE;
                end
            end
            default: begin
                res.inst = item_reg.inst;
                if (item_reg.inst < eff_nte) begin
                    res.status = ST_OUTDATED;
                end else if (inst_gap >= 32'(WINDOW)) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    ram_we = 1'b1;
                    if (base.chosen) begin
                        res.status = ST_ALREADY;
                    end else if (item_reg.req == REQ_CHOSEN) begin
                        wr_entry.bnum   = item_reg.bnum;
                        wr_entry.bprop  = item_reg.bprop;
                        wr_entry.val    = item_reg.val;
                        wr_entry.chosen = 1'b1;
                        choose = 1'b1;
                    end else if (older) begin
                        res.status = ST_OLD_BALLOT;
                    end else begin
                        if (newer) begin
                            wr_entry.bnum  = item_reg.bnum;
                            wr_entry.bprop = item_reg.bprop;
                            wr_entry.val   = item_reg.val;
                            wr_entry.votes = '0;
                        end
                        votes2 = wr_entry.votes | bit_mask;
                        cnt    = 5'($countones(votes2));
                        if ((7'(item_reg.aid) >= limit) ||
                            ((wr_entry.votes & bit_mask) != '0)) begin
                            res.status = ST_DUPLICATE;
                        end else begin
                            wr_entry.votes = votes2;
                            if (cnt >= quorum_reg) begin
                                wr_entry.chosen = 1'b1;
                                choose = 1'b1;
                            end else begin
                                res.status = ST_COUNTED;
                            end
                        end
                    end
                    if (choose) begin
                        res.status = ST_CHOSEN;
                        res.bnum   = item_reg.bnum;
                        res.bprop  = item_reg.bprop;
                        res.val    = item_reg.val;
                    end
                end
            end
        endcase
    end

    // sequencer, learner state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            nte_reg      <= 32'd1;
            nte_slot_reg <= IDXW'(1);
            hc_reg       <= 32'd0;
            await_reg    <= 1'b0;
            quorum_reg   <= 5'd2;
            acc_reg      <= 5'd3;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_QUORUM:    quorum_reg <= cfg_wdata[4:0];
                    CFG_ACCEPTORS: acc_reg    <= cfg_wdata[4:0];
                    CFG_CATCH_UP:  await_reg  <= !cfg_wdata[0];
                    CFG_START: begin
                        nte_reg <= cfg_wdata + 32'd1;
                        hc_reg  <= cfg_wdata;
                    end
                endcase
            end
            if (m_valid_reg && m_ready && !commit) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_pop) begin
                        if (q_item.sync) begin
                            nte_slot_reg <= q_slot;
                        end else begin
                            item_reg  <= q_item;
                            slot_reg  <= rd_addr;
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    if (commit) begin
                        state_reg   <= S_IDLE;
                        res_reg     <= res;
                        m_valid_reg <= 1'b1;
                        if (item_reg.req == REQ_VOTE || item_reg.req == REQ_CHOSEN) begin
                            if (await_reg) begin
                                await_reg    <= 1'b0;
                                nte_reg      <= item_reg.inst;
                                nte_slot_reg <= slot_reg;
                            end
                            if (ram_we) begin
                                valid_reg[slot_reg] <= 1'b1;
                            end
                            if (choose && (item_reg.inst > hc_reg)) begin
                                hc_reg <= item_reg.inst;
                            end
                        end else if (item_reg.req == REQ_DELIVER && dlv_hit) begin
                            valid_reg[slot_reg] <= 1'b0;
                            nte_reg <= nte_reg + 32'd1;
                            // instance zero after the wrap lives in slot zero
                            if ((nte_slot_reg == IDXW'(WINDOW - 1)) ||
                                (nte_reg == 32'hFFFF_FFFF)) begin
                                nte_slot_reg <= '0;
                            end else begin
                                nte_slot_reg <= nte_slot_reg + IDXW'(1);
                            end
                        end
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: design/consensus_learner_quorum_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Paxos learner over a table of WINDOW instance slots (slot = instance mod WINDOW).
// Each transaction on the s_ channel yields exactly one result transaction on the
// m_ channel. A three-stage front end works out the slot index and feeds a
// two-entry queue; the back end reads the slot from the table as it pops a
// transaction, then does one read-modify-write of the slot, and pops the next
// transaction only after that result is registered. A result that is not
// taken holds the back end, which then backs up the queue and the front end. The
// table needs no clearing pass after reset. Configuration writes (cfg_we,
// cfg_index, cfg_wdata) take effect at once and must be made by the user only
// while no transaction is in flight; the block itself does not enforce this.
module consensus_learner_quorum_table #(
    parameter int WINDOW = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [31:0] s_instance_id,
    input  wire logic [31:0] s_ballot_number,
    input  wire logic [7:0]  s_proposer_id,
    input  wire logic [3:0]  s_acceptor_id,
    input  wire logic [31:0] s_value_handle,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_status,
    output logic [31:0]      m_out_instance,
    output logic [31:0]      m_out_ballot_number,
    output logic [7:0]       m_out_proposer,
    output logic [31:0]      m_out_value,
    output logic             m_has_holes,
    output logic [31:0]      m_hole_from,
    output logic [31:0]      m_hole_to,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);
    import clqt_pkg::*;

    localparam int IDXW = $clog2(WINDOW);
    localparam int QW   = $bits(item_t) + IDXW;

    item_t           s_item, f_item, q_item;
    logic [IDXW-1:0] f_slot, q_slot;
    logic            f_push, q_full, q_nempty, q_pop;
    logic [QW-1:0]   q_head;
    result_t         res;

    // input transaction bundle
    always_comb begin
        s_item       = '0;
        s_item.req   = s_req_type;
        s_item.inst  = s_instance_id;
        s_item.bnum  = s_ballot_number;
        s_item.bprop = s_proposer_id;
        s_item.aid   = s_acceptor_id;
        s_item.val   = s_value_handle;
    end

    clqt_front #(.WINDOW(WINDOW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .push      (f_push),
        .push_item (f_item),
        .push_slot (f_slot),
        .q_full    (q_full)
    );

    clqt_queue #(.WIDTH(QW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_push),
        .push_data ({f_item, f_slot}),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_nempty),
        .full      (q_full)
    );

    assign q_item = q_head[QW-1:IDXW];
    assign q_slot = q_head[IDXW-1:0];

    clqt_back #(.WINDOW(WINDOW)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_nempty),
        .q_item    (q_item),
        .q_slot    (q_slot),
        .q_pop     (q_pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (res)
    );

    assign m_status            = res.status;
    assign m_out_instance      = res.inst;
    assign m_out_ballot_number = res.bnum;
    assign m_out_proposer      = res.bprop;
    assign m_out_value         = res.val;
    assign m_has_holes         = res.has_holes;
    assign m_hole_from         = res.hole_from;
    assign m_hole_to           = res.hole_to;

    // queue never takes a transaction while full
    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        f_push |-> !q_full)
        else $error("queue overflow");

    // back end never pops an empty queue
    a_queue_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_nempty)
        else $error("queue underflow");

    // hole flag only with the hole status
    a_holes_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_has_holes == (m_status == ST_HOLES)))
        else $error("hole flag mismatch");

    // no input taken during a configuration write
    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |-> !s_ready)
        else $error("input taken during configuration write");
endmodule
`default_nettype wire
